// ----- rtl/circle_tessellation_generator_core_assert.svh -----
// Assertion macros for the circle tessellation generator.
`ifndef CIRCLE_TESSELLATION_GENERATOR_CORE_ASSERT_SVH
`define CIRCLE_TESSELLATION_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define CTG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define CTG_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTG_ASSERT(lbl, prop, msg)
`define CTG_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// ----- rtl/ctg_pkg.sv -----
// Shared types and constants of the circle tessellation generator.
`timescale 1ns / 1ps
package ctg_pkg;

    // Side counter, configuration index and configuration data widths
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Phase divider: dividend holds an angle index above 32 fraction bits
    localparam int DIV_W      = CNT_W + 32;
    localparam int DIV_STEPS  = DIV_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);
    localparam int DIVISOR_W  = 7;

    // Series terms: four sine terms, then five cosine terms
    localparam int NUM_TERMS  = 9;
    localparam int TERM_W     = 4;
    localparam logic [TERM_W-1:0] COS_FIRST = 4'd4;
    localparam logic [TERM_W-1:0] TERM_LAST = 4'd8;

    // Each term divisor is 2^a times an odd factor o. The dividend is first
    // shifted right by a, which leaves at most 31 bits, and then multiplied
    // by ceil(2^(31+l) / o) with l = ceil(log2(o)); the quotient is the
    // product shifted right by 31+l, exact for every 31-bit dividend.
    // Divisors in order: 6, 20, 42, 72, then 2, 12, 30, 56, 90.
    localparam logic [1:0] TERM_PRE [NUM_TERMS] =
        '{2'd1, 2'd2, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1, 2'd3, 2'd1};
    localparam logic [5:0] TERM_SH [NUM_TERMS] =
        '{6'd33, 6'd34, 6'd36, 6'd35, 6'd31, 6'd33, 6'd35, 6'd34, 6'd37};
    localparam logic [31:0] TERM_MAG [NUM_TERMS] =
        '{32'(((64'd1 << 33) + 64'd2) / 64'd3),
          32'(((64'd1 << 34) + 64'd4) / 64'd5),
          32'(((64'd1 << 36) + 64'd20) / 64'd21),
          32'(((64'd1 << 35) + 64'd8) / 64'd9),
          32'(64'd1 << 31),
          32'(((64'd1 << 33) + 64'd2) / 64'd3),
          32'(((64'd1 << 35) + 64'd14) / 64'd15),
          32'(((64'd1 << 34) + 64'd6) / 64'd7),
          32'(((64'd1 << 37) + 64'd44) / 64'd45)};

    // Low 32 bits of 2*pi in Q32; the integer part is 6
    localparam logic [31:0] ANGLE_LO = 32'h487E_D511;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIDE_COUNT = 2'd0,
        CFG_RADIUS     = 2'd1,
        CFG_MODE       = 2'd2
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_PHASE_WAIT,
        ST_FMUL,
        ST_FANG,
        ST_X2MUL,
        ST_X2SET,
        ST_TMUL,
        ST_TDIV,
        ST_TWAIT,
        ST_XMUL,
        ST_XOUT,
        ST_YMUL,
        ST_YOUT,
        ST_EMIT
    } ctg_state_t;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/ctg_div.sv -----
// Bit-serial restoring divider for the polygon phase step.
`timescale 1ns / 1ps
module ctg_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctg_pkg::div_req_t req,
    output ctg_pkg::div_rsp_t rsp
);
    import ctg_pkg::*;

    logic [STEP_W-1:0]    cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;
    logic [DIVISOR_W:0]   rem_new;

    // One quotient bit per cycle
    always_comb
    begin
        trial   = {rem_reg, quo_reg[DIV_W-1]};
        fits    = (trial >= {1'b0, dvs_reg});
        rem_new = fits ? (trial - {1'b0, dvs_reg}) : trial;
    end

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= STEP_W'(DIV_STEPS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: quotient and partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_new[DIVISOR_W-1:0];
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/circle_tessellation_generator_core.sv -----
// Top level of the circle tessellation generator.
//
// The s channel takes one centre point per word. For it the block emits one
// word per polygon side on the m channel, n words in all, where n is the
// side count clamped to 1..MAX_SIDES. Each word holds the edge points at
// angle indexes i+1 and i, the centre as fan apex (zero in outline mode),
// and tlast marks the last side of the centre.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. A write takes effect at once.
// Every edge point runs the phase division on the 39-step bit-serial
// divider, then folds and squares the angle, then works nine series terms
// (multiply, reciprocal multiply, accumulate) on the one shared multiplier,
// and last scales and saturates both coordinates. A centre needs n+1
// points and one load of the output register per word; the block takes no
// new centre until the last word of the current one is loaded.
// A single output register holds the finished word; while the receiver
// stalls, the sequencer waits in front of it. s_tready is high only when
// no centre is in work. Reset clears the configuration to 16 sides,
// radius 1.0 and fan mode, and empties the output register.
`timescale 1ns / 1ps
`include "circle_tessellation_generator_core_assert.svh"
module circle_tessellation_generator_core
#(
    parameter int MAX_SIDES      = 64,
    parameter int TRIG_FRAC_BITS = 15
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ctg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [63:0]                      s_tdata,   // center_x, center_y
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [191:0]                     m_tdata,   // next_x, next_y, this_x,
                                                        // this_y, apex_x, apex_y
    output logic                             m_tlast    // final_side
);
    import ctg_pkg::*;

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_SIDES);
    localparam int MT_W      = TRIG_FRAC_BITS + 1;
    localparam int RND_SHIFT = 32 - TRIG_FRAC_BITS;
    localparam logic [32:0] TRIG_HALF = 33'(1) << (31 - TRIG_FRAC_BITS);
    localparam logic [63:0] RAD_HALF  = 64'(1) << (TRIG_FRAC_BITS - 1);

    // Configuration registers
    logic [CNT_W-1:0]  side_count_reg;
    logic [30:0]       radius_reg;
    logic              mode_reg;

    // Sequencer and counters
    ctg_state_t        state_reg;
    ctg_state_t        state_next;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [TERM_W-1:0] term_reg;

    // Datapath registers
    logic [31:0]  cx_reg;
    logic [31:0]  cy_reg;
    logic [1:0]   quad_reg;
    logic         swap_reg;
    logic [29:0]  rr_reg;
    logic [31:0]  ang_reg;
    logic [31:0]  x2_reg;
    logic [31:0]  t_reg;
    logic [32:0]  sin_reg;
    logic [32:0]  cos_reg;
    logic [63:0]  prod_reg;
    logic [31:0]  px_reg;
    logic [31:0]  py_reg;
    logic [31:0]  prev_x_reg;
    logic [31:0]  prev_y_reg;
    logic [191:0] out_data_reg;
    logic         out_last_reg;
    logic         out_valid_reg;

    // Combinational signals
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [CNT_W-1:0]  n_eff;
    logic [31:0]       phase;
    logic [30:0]       rr_wide;
    logic [29:0]       rr_new;
    logic [31:0]       ang_new;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;
    logic [31:0]       term_div;
    logic [31:0]       term_pre;
    logic [63:0]       term_wide;
    logic [31:0]       term_q;
    logic              term_sub;
    logic [32:0]       sin_upd;
    logic [32:0]       cos_upd;
    logic [32:0]       s_val;
    logic [32:0]       c_val;
    logic [32:0]       sm;
    logic [32:0]       cm;
    logic              sn;
    logic              cn;
    logic [32:0]       rnd_x;
    logic [32:0]       rnd_y;
    logic [MT_W-1:0]   mt_x;
    logic [MT_W-1:0]   mt_y;
    logic [63:0]       sc_sum;
    logic [31:0]       off_mag;
    logic              off_neg;
    logic [31:0]       ctr;
    logic [33:0]       off;
    logic [33:0]       tot;
    logic [31:0]       sat;
    logic              emit_load;
    logic              emit_last;

    ctg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Effective side count
    always_comb
    begin
        if (side_count_reg == '0)
            n_eff = CNT_W'(1);
        else if (side_count_reg > MAX_N)
            n_eff = MAX_N;
        else
            n_eff = side_count_reg;
    end

    // Phase folding into one octant
    always_comb
    begin
        phase   = div_rsp.quotient[31:0];
        rr_wide = 31'h4000_0000 - {1'b0, phase[29:0]};
        rr_new  = phase[29] ? rr_wide[29:0] : phase[29:0];
        ang_new = 32'({rr_reg, 2'b00}) + 32'({rr_reg, 1'b0}) + prod_reg[63:32];
    end

    // Series term: divided by its constant through a reciprocal product
    always_comb
    begin
        term_div  = (term_reg == COS_FIRST) ? x2_reg : prod_reg[63:32];
        term_pre  = term_div >> TERM_PRE[term_reg];
        term_wide = prod_reg >> TERM_SH[term_reg];
        term_q    = term_wide[31:0];
        term_sub  = !term_reg[0];
        sin_upd   = term_sub ? (sin_reg - {1'b0, term_q}) : (sin_reg + {1'b0, term_q});
        cos_upd   = term_sub ? (cos_reg - {1'b0, term_q}) : (cos_reg + {1'b0, term_q});
    end

    // Octant swap, quadrant sign and rounding to the trig precision
    always_comb
    begin
        s_val = swap_reg ? cos_reg : sin_reg;
        c_val = swap_reg ? sin_reg : cos_reg;
        case (quad_reg)
            2'd0:
            begin
                sm = s_val; sn = 1'b0; cm = c_val; cn = 1'b0;
            end
            2'd1:
            begin
                sm = c_val; sn = 1'b0; cm = s_val; cn = 1'b1;
            end
            2'd2:
            begin
                sm = s_val; sn = 1'b1; cm = c_val; cn = 1'b1;
            end
            default:
            begin
                sm = c_val; sn = 1'b1; cm = s_val; cn = 1'b0;
            end
        endcase
        rnd_x = sm + TRIG_HALF;
        rnd_y = cm + TRIG_HALF;
        mt_x  = rnd_x[32:RND_SHIFT];
        mt_y  = rnd_y[32:RND_SHIFT];
    end

    // Shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_FMUL:
            begin
                mul_a = {2'b00, rr_reg};
                mul_b = ANGLE_LO;
            end
            ST_X2MUL:
            begin
                mul_a = ang_reg;
                mul_b = ang_reg;
            end
            ST_TMUL:
            begin
                mul_a = t_reg;
                mul_b = x2_reg;
            end
            ST_TDIV:
            begin
                mul_a = term_pre;
                mul_b = TERM_MAG[term_reg];
            end
            ST_XMUL:
            begin
                mul_a = {1'b0, radius_reg};
                mul_b = 32'(mt_x);
            end
            ST_YMUL:
            begin
                mul_a = {1'b0, radius_reg};
                mul_b = 32'(mt_y);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Radius scaling, centre offset and saturation
    always_comb
    begin
        sc_sum  = prod_reg + RAD_HALF;
        off_mag = sc_sum[TRIG_FRAC_BITS+31:TRIG_FRAC_BITS];
        off_neg = (state_reg == ST_XOUT) ? sn : cn;
        ctr     = (state_reg == ST_XOUT) ? cx_reg : cy_reg;
        off     = off_neg ? (34'd0 - {2'b00, off_mag}) : {2'b00, off_mag};
        tot     = {{2{ctr[31]}}, ctr} + off;
        if ((tot[33:31] == 3'b000) || (tot[33:31] == 3'b111))
            sat = tot[31:0];
        else if (tot[33])
            sat = 32'h8000_0000;
        else
            sat = 32'h7FFF_FFFF;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_PHASE;
            ST_PHASE:
                state_next = ST_PHASE_WAIT;
            ST_PHASE_WAIT:
                if (div_rsp.done)
                    state_next = ST_FMUL;
            ST_FMUL:
                state_next = ST_FANG;
            ST_FANG:
                state_next = ST_X2MUL;
            ST_X2MUL:
                state_next = ST_X2SET;
            ST_X2SET:
                state_next = ST_TMUL;
            ST_TMUL:
                state_next = ST_TDIV;
            ST_TDIV:
                state_next = ST_TWAIT;
            ST_TWAIT:
                state_next = (term_reg == TERM_LAST) ? ST_XMUL : ST_TMUL;
            ST_XMUL:
                state_next = ST_XOUT;
            ST_XOUT:
                state_next = ST_YMUL;
            ST_YMUL:
                state_next = ST_YOUT;
            ST_YOUT:
                state_next = (k_reg == '0) ? ST_PHASE : ST_EMIT;
            ST_EMIT:
                if (emit_load)
                    state_next = emit_last ? ST_IDLE : ST_PHASE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready         = (state_reg == ST_IDLE);
        emit_last        = (k_reg == n_reg);
        emit_load        = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
        div_req.start    = (state_reg == ST_PHASE);
        div_req.divisor  = n_reg;
        div_req.dividend = {k_reg, 32'd0} + DIV_W'(n_reg >> 1);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_count_reg <= CNT_W'(16);
            radius_reg     <= 31'd65536;
            mode_reg       <= 1'b0;
            state_reg      <= ST_IDLE;
            n_reg          <= CNT_W'(1);
            k_reg          <= '0;
            term_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SIDE_COUNT: side_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_RADIUS:     radius_reg     <= cfg_data;
                    CFG_MODE:       mode_reg       <= cfg_data[0];
                    default:        ;
                endcase
            end
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && s_tvalid)
            begin
                n_reg <= n_eff;
                k_reg <= '0;
            end
            if (state_reg == ST_X2SET)
                term_reg <= '0;
            if ((state_reg == ST_TWAIT) && (term_reg != TERM_LAST))
                term_reg <= term_reg + TERM_W'(1);
            if ((state_reg == ST_YOUT) && (k_reg == '0))
                k_reg <= CNT_W'(1);
            if (emit_load && !emit_last)
                k_reg <= k_reg + CNT_W'(1);
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && s_tvalid)
        begin
            cx_reg <= s_tdata[31:0];
            cy_reg <= s_tdata[63:32];
        end
        if ((state_reg == ST_PHASE_WAIT) && div_rsp.done)
        begin
            quad_reg <= phase[31:30];
            swap_reg <= phase[29];
            rr_reg   <= rr_new;
        end
        if ((state_reg == ST_FMUL) || (state_reg == ST_X2MUL) || (state_reg == ST_TMUL) ||
            (state_reg == ST_TDIV) || (state_reg == ST_XMUL) || (state_reg == ST_YMUL))
            prod_reg <= mul_p;
        if (state_reg == ST_FANG)
            ang_reg <= ang_new;
        if (state_reg == ST_X2SET)
        begin
            x2_reg  <= prod_reg[63:32];
            t_reg   <= ang_reg;
            sin_reg <= {1'b0, ang_reg};
            cos_reg <= 33'h1_0000_0000;
        end
        if (state_reg == ST_TWAIT)
        begin
            t_reg <= term_q;
            if (term_reg < COS_FIRST)
                sin_reg <= sin_upd;
            else
                cos_reg <= cos_upd;
        end
        if (state_reg == ST_XOUT)
            px_reg <= sat;
        if (state_reg == ST_YOUT)
        begin
            py_reg <= sat;
            if (k_reg == '0)
            begin
                prev_x_reg <= px_reg;
                prev_y_reg <= sat;
            end
        end
        if (emit_load)
        begin
            out_data_reg <= {mode_reg ? 32'd0 : cy_reg, mode_reg ? 32'd0 : cx_reg,
                             prev_y_reg, prev_x_reg, py_reg, px_reg};
            out_last_reg <= emit_last;
            prev_x_reg   <= px_reg;
            prev_y_reg   <= py_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Checks on the sequencer
    `CTG_ASSERT(a_div_start_free, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
    `CTG_ASSERT(a_k_bound, (state_reg != ST_IDLE) |-> (k_reg <= n_reg), "side index past count")
    `CTG_ASSERT(a_last_idle, (emit_load && emit_last) |=> (state_reg == ST_IDLE), "no idle after last")
    `CTG_ASSERT_NORST(a_n_range, !rst_n || ((n_reg != '0) && (n_reg <= MAX_N)), "side count out of range")

endmodule
